/* rtl/gtt_pkg.sv */
// Shared types and constants for the gesture tap-tempo tracker.
// Beat layouts, register indexes, reset values and the serial-unit control struct.
// No dependencies.
`default_nettype none

package gtt_pkg;

	// Serial units step one digit per cycle over this many digits
	localparam int unsigned NUM_DIGITS = 16;
	localparam int unsigned CNT_W      = $clog2(NUM_DIGITS);

	// Beats per minute times milliseconds
	localparam logic [15:0] TEMPO_DIVIDEND = 16'd60000;

	// Configuration register indexes
	localparam logic [2:0] REG_HANDEDNESS  = 3'd0;
	localparam logic [2:0] REG_INIT_TEMPO  = 3'd1;
	localparam logic [2:0] REG_SIM_THRESH  = 3'd2;
	localparam logic [2:0] REG_MIN_CONF    = 3'd3;
	localparam logic [2:0] REG_ZONE_HEIGHT = 3'd4;
	localparam logic [2:0] REG_TIMEOUT     = 3'd5;
	localparam logic [2:0] REG_MAX_TEMPO   = 3'd6;

	localparam int unsigned CFG_ADDR_W = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// Register reset values
	localparam logic        RST_HANDEDNESS  = 1'b1;
	localparam logic [8:0]  RST_INIT_TEMPO  = 9'd120;
	localparam logic [14:0] RST_SIM_THRESH  = 15'd15565;
	localparam logic [8:0]  RST_MIN_CONF    = 9'd128;
	localparam logic [10:0] RST_ZONE_HEIGHT = 11'd100;
	localparam logic [15:0] RST_TIMEOUT     = 16'd2000;
	localparam logic [8:0]  RST_MAX_TEMPO   = 9'd300;

	// Input beat, last field in the lowest bits
	typedef struct packed {
		logic [2:0]  pad;
		logic [31:0] timestamp_ms;
		logic [8:0]  hip_confidence;
		logic [14:0] head_y;
		logic [14:0] hip_y;
		logic [15:0] right_dir_y;
		logic [15:0] left_dir_y;
		logic [14:0] right_hand_y;
		logic [14:0] left_hand_y;
	} gtt_in_t;

	// Output beat, last field in the lowest bits
	typedef struct packed {
		logic [3:0] pad;
		logic       gesture_end;
		logic       gesture_start;
		logic [8:0] tempo_bpm;
		logic       beat;
	} gtt_out_t;

	// Sequencer control to the serial units
	typedef struct packed {
		logic load;
		logic step;
	} gtt_ser_ctl_t;

endpackage

`default_nettype wire

/* rtl/gtt_div3.sv */
// Bit-serial divide by three, MSB first, one quotient bit per step.
// Depends on gtt_pkg for the control struct and digit count.
`default_nettype none

module gtt_div3 (
	input  wire                                   clk,
	input  wire gtt_pkg::gtt_ser_ctl_t            ctl,
	input  wire [gtt_pkg::NUM_DIGITS-1:0]         dividend,
	output logic [gtt_pkg::NUM_DIGITS-1:0]        quotient
);

	logic [gtt_pkg::NUM_DIGITS-1:0] sh_q;
	logic [1:0]                     rem_q;
	logic [2:0]                     trial;
	logic                           ge;
	logic [2:0]                     diff;
	logic [1:0]                     rem_nxt;

	// Partial remainder with the next dividend bit appended
	always_comb begin
		trial   = {rem_q, sh_q[gtt_pkg::NUM_DIGITS-1]};
		ge      = (trial >= 3'd3);
		diff    = trial - 3'd3;
		rem_nxt = ge ? diff[1:0] : trial[1:0];
	end

	// Dividend shifts out at the top while quotient bits shift in below
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			sh_q  <= dividend;
			rem_q <= 2'd0;
		end else if (ctl.step) begin
			sh_q  <= {sh_q[gtt_pkg::NUM_DIGITS-2:0], ge};
			rem_q <= rem_nxt;
		end
	end

	assign quotient = sh_q;

endmodule

`default_nettype wire

/* rtl/gtt_divu.sv */
// Bit-serial restoring divider: fixed 60000 over a 16-bit divisor.
// Depends on gtt_pkg for the control struct, digit count and dividend.
`default_nettype none

module gtt_divu (
	input  wire                                   clk,
	input  wire gtt_pkg::gtt_ser_ctl_t            ctl,
	input  wire [gtt_pkg::NUM_DIGITS-1:0]         divisor,
	output logic [gtt_pkg::NUM_DIGITS-1:0]        quotient
);

	localparam int unsigned W = gtt_pkg::NUM_DIGITS;

	logic [W-1:0] sh_q;
	logic [W-1:0] div_q;
	logic [W-1:0] rem_q;
	logic [W:0]   trial;
	logic [W:0]   diff;
	logic         ge;
	logic [W-1:0] rem_nxt;

	always_comb begin
		trial   = {rem_q, sh_q[W-1]};
		ge      = (trial >= {1'b0, div_q});
		diff    = trial - {1'b0, div_q};
		rem_nxt = ge ? diff[W-1:0] : trial[W-1:0];
	end

	// Remainder stays below the divisor, so it fits W bits
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			sh_q  <= gtt_pkg::TEMPO_DIVIDEND;
			div_q <= divisor;
			rem_q <= '0;
		end else if (ctl.step) begin
			sh_q  <= {sh_q[W-2:0], ge};
			rem_q <= rem_nxt;
		end
	end

	assign quotient = sh_q;

endmodule

`default_nettype wire

/* rtl/gesture_tap_tempo_tracker_top.sv */
// Top level of the gesture tap-tempo tracker: stream ports, config registers,
// frame sequencer and gesture state. Uses gtt_pkg, gtt_div3 and gtt_divu.
//
// Usage
//   Slave stream (s_*) takes one skeleton frame per beat; master stream (m_*)
//   returns exactly one result beat per frame, in order.
//   Configuration is a plain write port (cfg_we, cfg_addr, cfg_wdata); write it
//   only while no frame is in flight. Writing initial_tempo also loads the
//   current tempo.
//   Two bit-serial units (zone bottom divide by three, 60000 / elapsed ms)
//   are loaded at the accepting edge, then run side by side in ST_RUN, one
//   quotient bit each per cycle; the decision follows in ST_DECIDE. A new
//   frame is taken only once the last one is written to the output
//   register: the input reopens at the edge that writes the result.
//   s_tready is high whenever no frame is being worked on, including while a
//   finished result waits in the output register.
//   When the receiver stalls, the next frame is taken and worked on, then
//   held in the decision cycle until the output register frees up.
//   Reset (arst_n low) clears the handshakes, loads every config register with
//   its default, drops any gesture and sets tempo to the initial tempo.
`default_nettype none

module gesture_tap_tempo_tracker_top (
	input  wire                                    clk,
	input  wire                                    arst_n,
	// Frame in
	input  wire                                    s_tvalid,
	output logic                                   s_tready,
	// s_tdata, low bit up: left_hand_y[15], right_hand_y[15], left_dir_y[16],
	// right_dir_y[16], hip_y[15], head_y[15], hip_confidence[9],
	// timestamp_ms[32], zero pad[3]
	input  wire [135:0]                            s_tdata,
	// Result out
	output logic                                   m_tvalid,
	input  wire                                    m_tready,
	// m_tdata, low bit up: beat[1], tempo_bpm[9], gesture_start[1],
	// gesture_end[1], zero pad[4]
	output logic [15:0]                            m_tdata,
	// Configuration write
	input  wire                                    cfg_we,
	input  wire [gtt_pkg::CFG_ADDR_W-1:0]          cfg_addr,
	input  wire [gtt_pkg::CFG_DATA_W-1:0]          cfg_wdata
);

	localparam int unsigned W     = gtt_pkg::NUM_DIGITS;
	localparam int unsigned CNT_W = gtt_pkg::CNT_W;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_RUN    = 2'd1;
	localparam logic [1:0] ST_DECIDE = 2'd2;

	// Configuration registers
	logic        handedness_q;
	logic [14:0] sim_thresh_q;
	logic [8:0]  min_conf_q;
	logic [10:0] zone_height_q;
	logic [15:0] timeout_q;
	logic [8:0]  max_tempo_q;

	// Gesture state
	logic        in_zone_q;
	logic        started_q;
	logic [31:0] start_time_q;
	logic [8:0]  tempo_q;

	// Sequencer
	logic [1:0]       st_q;
	logic [CNT_W-1:0] cnt_q;

	// Frame held for the decision
	gtt_pkg::gtt_in_t frm_in;
	gtt_pkg::gtt_in_t frm_q;
	logic             span_neg_q;
	logic             el_zero_q;
	logic             el_big_q;
	logic             timeout_hit_q;

	// Output register
	logic              out_valid_q;
	gtt_pkg::gtt_out_t out_q;

	logic                  accept;
	logic                  out_free;
	logic                  commit;
	gtt_pkg::gtt_ser_ctl_t ser_ctl;

	logic [15:0] span;
	logic [15:0] span_mag;
	logic [31:0] elapsed;
	logic [W-1:0] q3;
	logic [W-1:0] qt;

	// Decision signals
	logic [14:0] hand_sel;
	logic [15:0] dir_sel;
	logic        dir_neg;
	logic [16:0] dir_mag;
	logic [17:0] q3_s;
	logic [17:0] bottom;
	logic [17:0] top;
	logic [17:0] hand_x;
	logic        in_rng;
	logic        frame_ok;
	logic        over;

	logic        n_in_zone;
	logic        n_started;
	logic [31:0] n_start_time;
	logic [8:0]  n_tempo;
	logic        f_beat;
	logic        f_start;
	logic        f_end;

	assign frm_in   = gtt_pkg::gtt_in_t'(s_tdata);
	assign s_tready = (st_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign commit   = (st_q == ST_DECIDE) && out_free;

	assign ser_ctl = '{load: accept, step: (st_q == ST_RUN)};

	// Head-to-hip span and elapsed time, taken straight off the incoming beat
	always_comb begin
		span     = {frm_in.head_y[14], frm_in.head_y} - {frm_in.hip_y[14], frm_in.hip_y};
		span_mag = span[15] ? (16'd0 - span) : span;
		elapsed  = frm_in.timestamp_ms - start_time_q;
	end

	gtt_div3 u_div3 (
		.clk      (clk),
		.ctl      (ser_ctl),
		.dividend (span_mag),
		.quotient (q3)
	);

	gtt_divu u_divu (
		.clk      (clk),
		.ctl      (ser_ctl),
		.divisor  (elapsed[W-1:0]),
		.quotient (qt)
	);

	// Gesture decision from the held frame and both quotients
	always_comb begin
		hand_sel = handedness_q ? frm_q.right_hand_y : frm_q.left_hand_y;
		dir_sel  = handedness_q ? frm_q.right_dir_y : frm_q.left_dir_y;
		dir_neg  = dir_sel[15];
		dir_mag  = dir_neg ? (17'd0 - {dir_sel[15], dir_sel}) : {dir_sel[15], dir_sel};

		// Truncate toward zero: divide the magnitude, then restore the sign
		q3_s   = span_neg_q ? (18'd0 - {2'b00, q3}) : {2'b00, q3};
		bottom = {{3{frm_q.hip_y[14]}}, frm_q.hip_y} + q3_s;
		top    = bottom + {7'd0, zone_height_q};
		hand_x = {{3{hand_sel[14]}}, hand_sel};
		in_rng = ($signed(hand_x) >= $signed(bottom)) && ($signed(hand_x) <= $signed(top));

		frame_ok = (frm_q.hip_confidence >= min_conf_q) && (dir_mag >= {2'b00, sim_thresh_q});

		// Zero elapsed counts as too fast; an interval past 60 s gives tempo zero
		if (el_zero_q) begin
			over = 1'b1;
		end else if (el_big_q) begin
			over = 1'b0;
		end else begin
			over = (qt > {7'd0, max_tempo_q});
		end

		n_in_zone    = in_zone_q;
		n_started    = started_q;
		n_start_time = start_time_q;
		n_tempo      = tempo_q;
		f_beat       = 1'b0;
		f_start      = 1'b0;
		f_end        = 1'b0;

		if (frame_ok) begin
			if (started_q && timeout_hit_q) begin
				n_started = 1'b0;
				f_end     = 1'b1;
			end else if (!in_zone_q) begin
				if (in_rng && dir_neg) begin
					n_in_zone = 1'b1;
					if (!started_q) begin
						f_start      = 1'b1;
						n_start_time = frm_q.timestamp_ms;
						n_started    = 1'b1;
					end else if (over) begin
						n_started = 1'b0;
						f_end     = 1'b1;
					end else begin
						n_tempo      = el_big_q ? 9'd0 : qt[8:0];
						n_start_time = frm_q.timestamp_ms;
						f_beat       = 1'b1;
					end
				end
			end else if (!in_rng) begin
				n_in_zone = 1'b0;
			end
		end
	end

	// Control state, configuration and gesture state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			handedness_q  <= gtt_pkg::RST_HANDEDNESS;
			sim_thresh_q  <= gtt_pkg::RST_SIM_THRESH;
			min_conf_q    <= gtt_pkg::RST_MIN_CONF;
			zone_height_q <= gtt_pkg::RST_ZONE_HEIGHT;
			timeout_q     <= gtt_pkg::RST_TIMEOUT;
			max_tempo_q   <= gtt_pkg::RST_MAX_TEMPO;
			in_zone_q     <= 1'b0;
			started_q     <= 1'b0;
			start_time_q  <= 32'd0;
			tempo_q       <= gtt_pkg::RST_INIT_TEMPO;
			st_q          <= ST_IDLE;
			cnt_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			// Drop the result once taken, unless a new one replaces it below
			if (m_tready && !commit) begin
				out_valid_q <= 1'b0;
			end

			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						st_q  <= ST_RUN;
						cnt_q <= CNT_W'(W - 1);
					end
				end
				ST_RUN: begin
					if (cnt_q == '0) begin
						st_q <= ST_DECIDE;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				ST_DECIDE: begin
					// Hold here until the output register frees up
					if (out_free) begin
						st_q         <= ST_IDLE;
						out_valid_q  <= 1'b1;
						in_zone_q    <= n_in_zone;
						started_q    <= n_started;
						start_time_q <= n_start_time;
						tempo_q      <= n_tempo;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase

			if (cfg_we) begin
				unique case (cfg_addr)
					gtt_pkg::REG_HANDEDNESS:  handedness_q  <= cfg_wdata[0];
					gtt_pkg::REG_INIT_TEMPO:  tempo_q       <= cfg_wdata[8:0];
					gtt_pkg::REG_SIM_THRESH:  sim_thresh_q  <= cfg_wdata[14:0];
					gtt_pkg::REG_MIN_CONF:    min_conf_q    <= cfg_wdata[8:0];
					gtt_pkg::REG_ZONE_HEIGHT: zone_height_q <= cfg_wdata[10:0];
					gtt_pkg::REG_TIMEOUT:     timeout_q     <= cfg_wdata;
					gtt_pkg::REG_MAX_TEMPO:   max_tempo_q   <= cfg_wdata[8:0];
					default: begin
					end
				endcase
			end
		end
	end

	// Frame payload and elapsed-time flags, captured on accept
	always_ff @(posedge clk) begin
		if (accept) begin
			frm_q         <= frm_in;
			span_neg_q    <= span[15];
			el_zero_q     <= (elapsed == 32'd0);
			el_big_q      <= (elapsed[31:W] != '0);
			timeout_hit_q <= (elapsed[31:W] != '0) || (elapsed[W-1:0] >= timeout_q);
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (commit) begin
			out_q.pad           <= '0;
			out_q.gesture_end   <= f_end;
			out_q.gesture_start <= f_start;
			out_q.tempo_bpm     <= n_tempo;
			out_q.beat          <= f_beat;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	// At most one event per result
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $onehot0({out_q.beat, out_q.gesture_start, out_q.gesture_end}))
		else $error("more than one gesture event in a result");

	// The serial phase ends in the decision state once the step counter is zero
	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_RUN && cnt_q == '0) |=> (st_q == ST_DECIDE))
		else $error("serial phase overran");

	// An end event always leaves no gesture running
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && f_end) |=> !started_q)
		else $error("gesture still running after end event");

	// An accepted beat never stores a tempo above the limit
	a_beat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && f_beat) |=> (tempo_q <= max_tempo_q))
		else $error("beat stored tempo above limit");

endmodule

`default_nettype wire

/* sim/gesture_tap_tempo_tracker_top_test.sv */
// Self-checking testbench for the gesture tap-tempo tracker: directed and random skeleton
// frames, a frame-level predictor of the gesture state and in-order result checking.
// Depends on gtt_pkg and gesture_tap_tempo_tracker_top.

module gesture_tap_tempo_tracker_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	// Watchdog limit, set well above the length of a correct run
	localparam int CYCLE_LIMIT  = 500000;
	// Extra settling time after the last owed result arrives
	localparam int DRAIN_CYCLES = 40;

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	// s_tdata, low bit up: left_hand_y, right_hand_y, left_dir_y, right_dir_y,
	// hip_y, head_y, hip_confidence, timestamp_ms, zero pad
	logic [135:0]                   s_tdata;
	logic                           m_tvalid;
	logic                           m_tready;
	// m_tdata, low bit up: beat, tempo_bpm, gesture_start, gesture_end, zero pad
	logic [15:0]                    m_tdata;
	logic                           cfg_we;
	logic [gtt_pkg::CFG_ADDR_W-1:0] cfg_addr;
	logic [gtt_pkg::CFG_DATA_W-1:0] cfg_wdata;

	gesture_tap_tempo_tracker_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	// 4 ns period
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Register copies as the tracker sees them
	logic        set_hand;
	logic [14:0] set_sim;
	logic [8:0]  set_min_conf;
	logic [10:0] set_zone;
	logic [15:0] set_timeout;
	logic [8:0]  set_max_tempo;

	// Gesture state of the predictor
	logic        trk_in_zone;
	logic        trk_started;
	logic [31:0] trk_since;
	logic [8:0]  trk_tempo;

	// Results owed by the tracker, oldest first
	gtt_pkg::gtt_out_t owed_results[$];
	int          mismatches   = 0;
	int          results_seen = 0;
	int          cycle_count  = 0;

	// Idling switches and the long receiver hold-off request
	bit          tx_idle   = 1'b1;
	bit          rx_idle   = 1'b1;
	int          sink_hold = 0;

	// Body placement for generated frames
	int          scene_hip;
	int          scene_head;
	logic [31:0] last_entry = '0;

	// Work out the result of one frame and advance the gesture state
	function automatic gtt_pkg::gtt_out_t predict_tempo(input gtt_pkg::gtt_in_t f);
		gtt_pkg::gtt_out_t r;
		int          hip, head, bottom, top, hand, dir, mag;
		logic [31:0] elapsed, quot;
		r = '0;
		if (f.hip_confidence >= set_min_conf) begin
			hip    = $signed(f.hip_y);
			head   = $signed(f.head_y);
			// signed int division truncates toward zero
			bottom = hip + (head - hip) / 3;
			top    = bottom + int'(set_zone);
			if (set_hand) begin
				hand = $signed(f.right_hand_y);
				dir  = $signed(f.right_dir_y);
			end else begin
				hand = $signed(f.left_hand_y);
				dir  = $signed(f.left_dir_y);
			end
			mag = (dir < 0) ? -dir : dir;
			if (mag >= int'(set_sim)) begin
				elapsed = f.timestamp_ms - trk_since;
				if (trk_started && elapsed >= 32'(set_timeout)) begin
					// timeout leaves the zone flag alone
					trk_started   = 1'b0;
					r.gesture_end = 1'b1;
				end else if (!trk_in_zone) begin
					if (hand >= bottom && hand <= top && dir < 0) begin
						trk_in_zone = 1'b1;
						if (!trk_started) begin
							r.gesture_start = 1'b1;
							trk_since       = f.timestamp_ms;
							trk_started     = 1'b1;
						end else begin
							// zero elapsed time counts as an excessive tempo
							if (elapsed != 0)
								quot = 32'd60000 / elapsed;
							else
								quot = '1;
							if (quot > 32'(set_max_tempo)) begin
								trk_started   = 1'b0;
								r.gesture_end = 1'b1;
							end else begin
								trk_tempo = quot[8:0];
								trk_since = f.timestamp_ms;
								r.beat    = 1'b1;
							end
						end
					end
				end else if (hand > top || hand < bottom) begin
					trk_in_zone = 1'b0;
				end
			end
		end
		r.tempo_bpm = trk_tempo;
		return r;
	endfunction

	// Build a frame around the tracked hand; the other hand gets random values
	function automatic gtt_pkg::gtt_in_t make_frame(input int hand_y, input int dir,
			input int conf, input logic [31:0] ts);
		gtt_pkg::gtt_in_t f;
		f.pad          = '0;
		f.left_hand_y  = 15'($urandom_range(0, 32767));
		f.right_hand_y = 15'($urandom_range(0, 32767));
		f.left_dir_y   = 16'($urandom_range(0, 32768) - 16384);
		f.right_dir_y  = 16'($urandom_range(0, 32768) - 16384);
		if (set_hand) begin
			f.right_hand_y = hand_y[14:0];
			f.right_dir_y  = dir[15:0];
		end else begin
			f.left_hand_y = hand_y[14:0];
			f.left_dir_y  = dir[15:0];
		end
		f.hip_y          = scene_hip[14:0];
		f.head_y         = scene_head[14:0];
		f.hip_confidence = conf[8:0];
		f.timestamp_ms   = ts;
		return f;
	endfunction

	function automatic int good_conf();
		return $urandom_range(set_min_conf, 256);
	endfunction

	// Direction strong enough to pass the threshold; down forces a negative sign
	function automatic int strong_dir(input bit down);
		int mag;
		mag = $urandom_range(set_sim, 16384);
		if (down || $urandom_range(0, 1))
			return -mag;
		return mag;
	endfunction

	function automatic int outside_hand(input int bottom, input int top);
		if ($urandom_range(0, 1))
			return top + 1 + $urandom_range(0, 400);
		return bottom - 1 - $urandom_range(0, 400);
	endfunction

	// Offer one frame after a random gap; predict its result once it is taken
	task automatic send_frame(input gtt_pkg::gtt_in_t f);
		int gap;
		gap = tx_idle ? $urandom_range(0, 17) : 0;
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= f;
		do @(posedge clk); while (!s_tready);
		owed_results.push_back(predict_tempo(f));
	endtask

	// Stop offering, wait for every owed result, then let the pipeline settle
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (owed_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [gtt_pkg::CFG_ADDR_W-1:0] idx,
			input int unsigned value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= value[gtt_pkg::CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			gtt_pkg::REG_HANDEDNESS:  set_hand = value[0];
			// initial tempo also reloads the running tempo
			gtt_pkg::REG_INIT_TEMPO:  trk_tempo     = value[8:0];
			gtt_pkg::REG_SIM_THRESH:  set_sim       = value[14:0];
			gtt_pkg::REG_MIN_CONF:    set_min_conf  = value[8:0];
			gtt_pkg::REG_ZONE_HEIGHT: set_zone      = value[10:0];
			gtt_pkg::REG_TIMEOUT:     set_timeout   = value[15:0];
			gtt_pkg::REG_MAX_TEMPO:   set_max_tempo = value[8:0];
			default: ;
		endcase
	endtask

	// Write all seven registers with the tracker idle
	task automatic apply_settings(input int unsigned hand, input int unsigned init_tempo,
			input int unsigned sim, input int unsigned min_conf, input int unsigned zone,
			input int unsigned timeout, input int unsigned max_tempo);
		drain_results();
		write_reg(gtt_pkg::REG_HANDEDNESS, hand);
		write_reg(gtt_pkg::REG_INIT_TEMPO, init_tempo);
		write_reg(gtt_pkg::REG_SIM_THRESH, sim);
		write_reg(gtt_pkg::REG_MIN_CONF, min_conf);
		write_reg(gtt_pkg::REG_ZONE_HEIGHT, zone);
		write_reg(gtt_pkg::REG_TIMEOUT, timeout);
		write_reg(gtt_pkg::REG_MAX_TEMPO, max_tempo);
	endtask

	// Pick a new body placement and sometimes jump the clock, wrap included
	task automatic new_scene();
		scene_hip  = $urandom_range(0, 6000) - 3000;
		scene_head = scene_hip + $urandom_range(0, 2400) - 600;
		if ($urandom_range(0, 3) == 0)
			last_entry = $urandom();
		else
			last_entry = last_entry + 3000;
	endtask

	// Mostly well-formed tap sequences with random timing, some noise and dropped frames
	task automatic run_gestures(input int count);
		gtt_pkg::gtt_in_t f;
		int      sent, pick, steps, interval, bottom, top, mag;
		sent = 0;
		new_scene();
		while (sent < count) begin
			bottom = scene_hip + (scene_head - scene_hip) / 3;
			top    = bottom + int'(set_zone);
			pick   = $urandom_range(0, 99);
			if (pick < 6) begin
				// anything the fields allow
				f.pad            = '0;
				f.left_hand_y    = 15'($urandom_range(0, 32767));
				f.right_hand_y   = 15'($urandom_range(0, 32767));
				f.left_dir_y     = 16'($urandom_range(0, 32768) - 16384);
				f.right_dir_y    = 16'($urandom_range(0, 32768) - 16384);
				f.hip_y          = 15'($urandom_range(0, 32767));
				f.head_y         = 15'($urandom_range(0, 32767));
				f.hip_confidence = 9'($urandom_range(0, 256));
				f.timestamp_ms   = $urandom_range(0, 1) ? $urandom() :
					last_entry + $urandom_range(0, 100);
				send_frame(f);
				sent++;
			end else if (pick < 14) begin
				// would enter the zone, but confidence or direction falls just short
				if (set_min_conf != 0 && (set_sim == 0 || $urandom_range(0, 1))) begin
					f = make_frame(bottom + $urandom_range(0, set_zone), strong_dir(1),
						$urandom_range(0, set_min_conf - 1), last_entry + $urandom_range(0, 300));
				end else if (set_sim != 0) begin
					mag = $urandom_range(0, set_sim - 1);
					f = make_frame(bottom + $urandom_range(0, set_zone),
						$urandom_range(0, 1) ? -mag : mag, good_conf(),
						last_entry + $urandom_range(0, 300));
				end else begin
					f = make_frame(outside_hand(bottom, top), strong_dir(0), good_conf(),
						last_entry + $urandom_range(0, 300));
				end
				send_frame(f);
				sent++;
			end else if (pick < 18) begin
				new_scene();
			end else begin
				// leave the zone a few times, then enter it after a chosen interval
				steps = $urandom_range(0, 3);
				case ($urandom_range(0, 9))
					0:       interval = $urandom_range(0, 200);
					1:       interval = set_timeout + $urandom_range(0, 500);
					2:       interval = 60000 / set_max_tempo + $urandom_range(0, 2) - 1;
					3:       interval = $urandom_range(1600, 70000);
					default: interval = $urandom_range(180, 1600);
				endcase
				for (int j = 1; j <= steps; j++) begin
					send_frame(make_frame(outside_hand(bottom, top), strong_dir(0), good_conf(),
						last_entry + interval * j / (steps + 1)));
					sent++;
				end
				last_entry = last_entry + interval;
				send_frame(make_frame(bottom + $urandom_range(0, set_zone), strong_dir(1),
					good_conf(), last_entry));
				sent++;
			end
		end
	endtask

	// Field extremes and every special case under the reset settings
	task automatic test_directed_defaults();
		gtt_pkg::gtt_in_t f;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		// all fields at their lowest, then at their highest
		f = '0;
		f.left_hand_y  = 15'h4000;
		f.right_hand_y = 15'h4000;
		f.left_dir_y   = 16'hC000;
		f.right_dir_y  = 16'hC000;
		f.hip_y        = 15'h4000;
		f.head_y       = 15'h4000;
		send_frame(f);
		f.left_hand_y    = 15'h3FFF;
		f.right_hand_y   = 15'h3FFF;
		f.left_dir_y     = 16'h4000;
		f.right_dir_y    = 16'h4000;
		f.hip_y          = 15'h3FFF;
		f.head_y         = 15'h3FFF;
		f.hip_confidence = 9'd256;
		f.timestamp_ms   = 32'hFFFF_FFFF;
		send_frame(f);
		// zone runs 1200..1300
		scene_hip  = 1000;
		scene_head = 1600;
		send_frame(make_frame(1250, -16000, 127, 32'd1000));   // confidence one short
		send_frame(make_frame(1250, -15564, 128, 32'd1000));   // direction one short
		send_frame(make_frame(1200, -15565, 128, 32'd1000));   // bottom edge starts gesture
		send_frame(make_frame(1301, 16000, 200, 32'd1100));    // leave above
		send_frame(make_frame(1300, -16384, 256, 32'd1500));   // top edge, 120 bpm
		send_frame(make_frame(1400, 16000, 200, 32'd1600));
		send_frame(make_frame(1250, -16000, 200, 32'd1500));   // no time passed: ends
		send_frame(make_frame(1100, 16000, 200, 32'd1600));    // leave below
		send_frame(make_frame(1250, -16000, 200, 32'd5000));   // new gesture
		send_frame(make_frame(1400, 16000, 200, 32'd5050));
		send_frame(make_frame(1250, -16000, 200, 32'd5100));   // 600 bpm is too fast
		send_frame(make_frame(1400, 16000, 200, 32'd5200));
		send_frame(make_frame(1250, -16000, 200, 32'd6000));
		send_frame(make_frame(1400, 16000, 200, 32'd6100));
		send_frame(make_frame(1250, -16000, 200, 32'd8000));   // timeout, zone flag kept
		send_frame(make_frame(1250, -16000, 200, 32'hFFFF_FE00));
		send_frame(make_frame(1400, 16000, 200, 32'hFFFF_FF00));
		send_frame(make_frame(1250, -16000, 200, 32'h0000_00C8)); // across the clock wrap
		// head below hip: bottom truncates toward zero, to 667
		scene_head = 0;
		send_frame(make_frame(900, 16000, 200, 32'd300));
		send_frame(make_frame(666, -16000, 200, 32'd400));
		send_frame(make_frame(667, -16000, 200, 32'd700));
		send_frame(make_frame(900, 16000, 200, 32'd800));
		send_frame(make_frame(700, 16000, 200, 32'd900));      // moving up: no entry
		send_frame(make_frame(700, -16000, 200, 32'd1200));
	endtask

	// Left hand, every threshold at zero, single-point zone, longest timeout
	task automatic test_low_settings();
		apply_settings(0, 1, 0, 0, 0, 65535, 1);
		scene_hip  = 0;
		scene_head = 300;
		send_frame(make_frame(100, -5, 0, 32'd1000));
		send_frame(make_frame(101, 0, 0, 32'd1100));
		send_frame(make_frame(100, -5, 0, 32'd62000));         // quotient 0 is kept
		send_frame(make_frame(99, 7, 0, 32'd62100));
		send_frame(make_frame(100, -1, 0, 32'd122000));        // exactly 1 bpm
		send_frame(make_frame(150, -200, 0, 32'd122500));
		send_frame(make_frame(100, -300, 0, 32'd152000));      // 2 bpm above limit
		send_frame(make_frame(500, 300, 0, 32'd152100));
		send_frame(make_frame(100, 0, 0, 32'd152200));         // zero direction is not down
		send_frame(make_frame(100, -1, 0, 32'd152300));
		run_gestures(160);
	endtask

	// Right hand, every threshold at its top, widest zone, shortest timeout
	task automatic test_high_settings();
		apply_settings(1, 300, 16384, 256, 2047, 1, 300);
		run_gestures(150);
	endtask

	// Fill the tracker against a stalled receiver, then run with random gaps and stalls
	task automatic test_backpressure();
		apply_settings(gtt_pkg::RST_HANDEDNESS, gtt_pkg::RST_INIT_TEMPO,
			gtt_pkg::RST_SIM_THRESH, gtt_pkg::RST_MIN_CONF, gtt_pkg::RST_ZONE_HEIGHT,
			gtt_pkg::RST_TIMEOUT, gtt_pkg::RST_MAX_TEMPO);
		tx_idle   = 1'b0;
		rx_idle   = 1'b0;
		sink_hold = 600;
		run_gestures(40);
		drain_results();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		run_gestures(40);
	endtask

	// Several random settings with each mix of idling
	task automatic test_random_settings();
		for (int p = 0; p < 6; p++) begin
			apply_settings($urandom_range(0, 1), $urandom_range(1, 300),
				$urandom_range(0, 3) == 0 ? $urandom_range(0, 16384) : $urandom_range(8000, 16384),
				$urandom_range(0, 256), $urandom_range(0, 2047),
				$urandom_range(0, 3) == 0 ? $urandom_range(1, 65535) : $urandom_range(400, 5000),
				$urandom_range(0, 3) == 0 ? $urandom_range(1, 300) : $urandom_range(150, 300));
			tx_idle = (p % 4 == 0) || (p % 4 == 2);
			rx_idle = (p % 4 == 0) || (p % 4 == 3);
			run_gestures(130);
		end
	endtask

	// Receiver: random stall before each beat, plus the long hold-off on request
	initial begin : result_sink
		int stall;
		@(posedge arst_n);
		forever begin
			if (sink_hold > 0) begin
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (sink_hold) @(negedge clk);
				sink_hold = 0;
			end
			stall = rx_idle ? $urandom_range(0, 17) : 0;
			if (stall > 0) begin
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Compare each accepted result with the oldest owed one
	always @(posedge clk) begin : result_check
		gtt_pkg::gtt_out_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			results_seen++;
			if (owed_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d arrived with no frame owed: %h", results_seen, m_tdata);
			end else begin
				want = owed_results.pop_front();
				if (got.beat !== want.beat || got.tempo_bpm !== want.tempo_bpm ||
						got.gesture_start !== want.gesture_start ||
						got.gesture_end !== want.gesture_end) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"result %0d: expected beat %0b tempo %0d start %0b end %0b,",
							" got beat %0b tempo %0d start %0b end %0b"}, results_seen,
							want.beat, want.tempo_bpm, want.gesture_start, want.gesture_end,
							got.beat, got.tempo_bpm, got.gesture_start, got.gesture_end);
				end
			end
		end
	end

	// Stop a hung run
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin : test_sequence
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		m_tready  = 1'b0;
		cfg_we    = 1'b0;
		cfg_addr  = '0;
		cfg_wdata = '0;
		arst_n    = 1'b0;
		// predictor starts from the reset settings
		set_hand      = gtt_pkg::RST_HANDEDNESS;
		set_sim       = gtt_pkg::RST_SIM_THRESH;
		set_min_conf  = gtt_pkg::RST_MIN_CONF;
		set_zone      = gtt_pkg::RST_ZONE_HEIGHT;
		set_timeout   = gtt_pkg::RST_TIMEOUT;
		set_max_tempo = gtt_pkg::RST_MAX_TEMPO;
		trk_in_zone   = 1'b0;
		trk_started   = 1'b0;
		trk_since     = '0;
		trk_tempo     = gtt_pkg::RST_INIT_TEMPO;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_defaults();
		test_low_settings();
		test_high_settings();
		test_backpressure();
		test_random_settings();
		drain_results();

		if (mismatches == 0 && owed_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
